### design/assert_macros.svh
// Assertion macros used by the top-level skinning design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a cause is followed by an effect in the next cycle.
`define LBS_ASSERT_NEXT(label, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (rst) cause |=> effect) else $error(msg);

`endif

### design/lbs_pkg.sv
// Types and constants of the linear blend skinning pipeline.
package lbs_pkg;

  localparam int WORDS_PER_BONE = 12;
  localparam int W_THRESH       = 66;
  localparam int PROD_W         = 48;
  localparam int WP_W           = 49;
  localparam int ACC_W          = 52;
  localparam int TOT_W          = 19;
  localparam int DIV_STEPS      = 32;
  localparam int REM_W          = 20;
  localparam int NUM_COMP       = 6;
  localparam int LANE_STAGES    = 4;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SKIN = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] nrm_x;
    logic [31:0] nrm_y;
    logic [31:0] nrm_z;
    logic [31:0] influence_ids;
    logic [63:0] influence_weights;
    logic [5:0]  load_bone;
    logic [3:0]  load_elem;
    logic [31:0] load_value;
  } in_t;

  typedef struct packed {
    logic [31:0] out_pos_x;
    logic [31:0] out_pos_y;
    logic [31:0] out_pos_z;
    logic [31:0] out_nrm_x;
    logic [31:0] out_nrm_y;
    logic [31:0] out_nrm_z;
    logic        passed_through;
  } out_t;

  typedef logic [NUM_COMP-1:0][31:0]   vec_t;
  typedef logic [NUM_COMP-1:0][WP_W-1:0] lane_res_t;

endpackage

### design/lbs_lane.sv
// One influence lane: bone matrix store, transform, saturate and weight.
module lbs_lane import lbs_pkg::*; #(
  parameter int MAX_BONES = 64,
  parameter int AW        = 6
) (
  input  logic                   clk,
  input  logic [LANE_STAGES-1:0] en,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [3:0]             wr_elem,
  input  logic [31:0]            wr_data,
  input  logic [AW-1:0]          rd_addr,
  input  logic [15:0]            weight,
  input  vec_t                   vec,
  output lane_res_t              res,
  output logic [15:0]            weight_out
);

  logic [31:0] mem [WORDS_PER_BONE][MAX_BONES];
  logic [31:0] m [WORDS_PER_BONE];
  vec_t        vec1;
  logic [15:0] w1, w2, w3;
  logic [2:0][2:0][PROD_W-1:0] pp, pn;
  logic [2:0][31:0] t2;
  logic [NUM_COMP-1:0][31:0] s3;

  function automatic logic [PROD_W-1:0] mulq(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction

  function automatic logic [31:0] sat_sum(logic signed [31:0] t, logic signed [PROD_W-1:0] a,
                                          logic signed [PROD_W-1:0] b,
                                          logic signed [PROD_W-1:0] c);
    logic signed [PROD_W+1:0] s;
    s = t + a + b + c;
    if ((s[PROD_W+1:31] == '0) || (s[PROD_W+1:31] == '1)) begin
      return s[31:0];
    end
    return s[PROD_W+1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [WP_W-1:0] wmul(logic signed [31:0] a, logic [15:0] w);
    logic signed [WP_W-1:0] p;
    p = a * $signed({1'b0, w});
    return p;
  endfunction

  always_ff @(posedge clk) begin
    for (int e = 0; e < WORDS_PER_BONE; e++) begin
      if (wr_en && (wr_elem == 4'(e))) begin
        mem[e][wr_addr] <= wr_data;
      end
      if (en[0]) begin
        m[e] <= mem[e][rd_addr];
      end
    end
    if (en[0]) begin
      vec1 <= vec;
      w1   <= weight;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      w2 <= w1;
      for (int r = 0; r < 3; r++) begin
        t2[r] <= m[r*4+3];
        for (int c = 0; c < 3; c++) begin
          pp[r][c] <= mulq(m[r*4+c], vec1[c]);
          pn[r][c] <= mulq(m[r*4+c], vec1[3+c]);
        end
      end
    end
    if (en[2]) begin
      w3 <= w2;
      for (int r = 0; r < 3; r++) begin
        s3[r]   <= sat_sum(t2[r], pp[r][0], pp[r][1], pp[r][2]);
        s3[3+r] <= sat_sum(32'sd0, pn[r][0], pn[r][1], pn[r][2]);
      end
    end
    if (en[3]) begin
      weight_out <= w3;
      for (int j = 0; j < NUM_COMP; j++) begin
        res[j] <= (w3 != '0) ? wmul(s3[j], w3) : '0;
      end
    end
  end

endmodule

### design/lbs_merge.sv
// Merge stage: sum weighted lane results and lane weights.
module lbs_merge import lbs_pkg::*; #(
  parameter int INFLUENCES = 4
) (
  input  logic                              clk,
  input  logic                              en,
  input  lane_res_t                         res [INFLUENCES],
  input  logic [INFLUENCES-1:0][15:0]       weight,
  output logic [NUM_COMP-1:0][ACC_W-1:0]    acc,
  output logic [TOT_W-1:0]                  total
);

  logic [NUM_COMP-1:0][ACC_W-1:0] acc_next;
  logic [TOT_W-1:0]               total_next;

  always_comb begin
    acc_next   = '0;
    total_next = '0;
    for (int k = 0; k < INFLUENCES; k++) begin
      total_next = total_next + TOT_W'(weight[k]);
      for (int j = 0; j < NUM_COMP; j++) begin
        acc_next[j] = acc_next[j] + ACC_W'($signed(res[k][j]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc   <= acc_next;
      total <= total_next;
    end
  end

endmodule

### design/lbs_div.sv
// Pipelined rounding divider, one quotient bit per stage.
module lbs_div import lbs_pkg::*; (
  input  logic                 clk,
  input  logic [DIV_STEPS:0]   en,
  input  logic [ACC_W-1:0]     num,
  input  logic [TOT_W-1:0]     den,
  output logic [31:0]          quo,
  output logic                 neg
);

  logic [DIV_STEPS:0][REM_W-1:0] rem;
  logic [DIV_STEPS:0][31:0]      word;
  logic [DIV_STEPS:0][TOT_W-1:0] dq;
  logic [DIV_STEPS:0]            sg;
  logic [DIV_STEPS:1][REM_W:0]   trial;
  logic [DIV_STEPS:1]            ge;
  logic [ACC_W-1:0]              mag;
  logic [ACC_W-1:0]              inc;
  logic [ACC_W:0]                sum;

  always_comb begin
    mag = num[ACC_W-1] ? ~num : num;
    inc = ACC_W'(den >> 1) + (num[ACC_W-1] ? ACC_W'(1) : ACC_W'(0));
    sum = (ACC_W+1)'(mag) + (ACC_W+1)'(inc);
    for (int s = 1; s <= DIV_STEPS; s++) begin
      trial[s] = {rem[s-1], word[s-1][31]};
      ge[s]    = trial[s] >= (REM_W+1)'(dq[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]  <= REM_W'(sum[ACC_W:32]);
      word[0] <= sum[31:0];
      dq[0]   <= den;
      sg[0]   <= num[ACC_W-1];
    end
    for (int s = 1; s <= DIV_STEPS; s++) begin
      if (en[s]) begin
        rem[s]  <= ge[s] ? REM_W'(trial[s] - (REM_W+1)'(dq[s-1])) : REM_W'(trial[s]);
        word[s] <= {word[s-1][30:0], ge[s]};
        dq[s]   <= dq[s-1];
        sg[s]   <= sg[s-1];
      end
    end
  end

  assign quo = word[DIV_STEPS];
  assign neg = sg[DIV_STEPS];

endmodule

### design/linear_blend_vertex_skinning.sv
// Linear blend vertex skinning, four influence lanes merged and divided.
//
//   channel | signals                     | word
//   in      | in_valid, in_ready, in_data  | load (cmd 0) or vertex (cmd 1)
//   out     | out_valid, out_ready, out_data | skinned vertex
//   cfg     | cfg_valid, cfg_ready, cfg_data | active bone count
//
// One word accepted per cycle while in_ready is high; a vertex result passes
// through four lane stages, the merge stage, the 33 divider stages and the
// output register. Loads write the bone store on acceptance and make no result.
// Synchronous reset clears valid bits and the bone count; the store is unset.
// A held output stalls only the stages that are full; empty stages keep filling.
`include "assert_macros.svh"

module linear_blend_vertex_skinning import lbs_pkg::*; #(
  parameter int MAX_BONES  = 64,
  parameter int INFLUENCES = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  localparam int AW     = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int LIM_W  = $clog2(MAX_BONES + 1);
  localparam int MRG_ST = LANE_STAGES + 1;
  localparam int DIV_ST = MRG_ST + 1;
  localparam int DEPTH  = DIV_ST + DIV_STEPS + 1;

  logic [6:0]       active;
  logic [LIM_W-1:0] limit;
  logic [DEPTH:1]   v;
  logic [DEPTH:1]   en;
  logic             take;
  logic             vertex_in;
  logic             load_in;
  vec_t             vin;
  vec_t             vtap [1:DEPTH-1];
  logic             ptap [DIV_ST:DEPTH-1];

  lane_res_t                        lane_res [INFLUENCES];
  logic [INFLUENCES-1:0][15:0]      lane_w;
  logic [NUM_COMP-1:0][ACC_W-1:0]   acc;
  logic [TOT_W-1:0]                 total;
  logic [NUM_COMP-1:0][31:0]        quo;
  logic [NUM_COMP-1:0]              qneg;
  logic [NUM_COMP-1:0][31:0]        blend;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cfg_valid && cfg_ready) begin
      active <= cfg_data;
    end
  end

  assign limit = (32'(active) < MAX_BONES) ? LIM_W'(active) : LIM_W'(MAX_BONES);

  always_comb begin
    for (int s = 1; s <= DEPTH; s++) begin
      en[s] = out_ready || (((~v) >> (s - 1)) != '0);
    end
  end

  assign in_ready  = en[1];
  assign take      = in_valid && in_ready;
  assign vertex_in = take && (in_data.cmd == CMD_SKIN);
  assign load_in   = take && (in_data.cmd == CMD_LOAD) && (32'(in_data.load_bone) < MAX_BONES)
                     && (in_data.load_elem < 4'(WORDS_PER_BONE));
  assign out_valid = v[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (v & ~en) | ({v[DEPTH-1:1], vertex_in} & en);
    end
  end

  assign vin = {in_data.nrm_z, in_data.nrm_y, in_data.nrm_x,
                in_data.pos_z, in_data.pos_y, in_data.pos_x};

  for (genvar k = 0; k < INFLUENCES; k++) begin : g_lane
    logic [7:0]  id;
    logic [15:0] w;
    logic [15:0] w_gated;
    if (k < 4) begin : g_field
      assign id = in_data.influence_ids[8*k +: 8];
      assign w  = in_data.influence_weights[16*k +: 16];
    end else begin : g_none
      assign id = '0;
      assign w  = '0;
    end
    assign w_gated = ((w != '0) && (32'(id) < 32'(limit))) ? w : '0;

    lbs_lane #(.MAX_BONES(MAX_BONES), .AW(AW)) u_lane (
      .clk        (clk),
      .en         (en[LANE_STAGES:1]),
      .wr_en      (load_in),
      .wr_addr    (AW'(in_data.load_bone)),
      .wr_elem    (in_data.load_elem),
      .wr_data    (in_data.load_value),
      .rd_addr    (AW'(id)),
      .weight     (w_gated),
      .vec        (vin),
      .res        (lane_res[k]),
      .weight_out (lane_w[k])
    );
  end

  lbs_merge #(.INFLUENCES(INFLUENCES)) u_merge (
    .clk    (clk),
    .en     (en[MRG_ST]),
    .res    (lane_res),
    .weight (lane_w),
    .acc    (acc),
    .total  (total)
  );

  for (genvar j = 0; j < NUM_COMP; j++) begin : g_div
    lbs_div u_div (
      .clk (clk),
      .en  (en[DIV_ST +: DIV_STEPS + 1]),
      .num (acc[j]),
      .den (total),
      .quo (quo[j]),
      .neg (qneg[j])
    );
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vtap[1] <= vin;
    end
    for (int s = 2; s < DEPTH; s++) begin
      if (en[s]) begin
        vtap[s] <= vtap[s-1];
      end
    end
    if (en[DIV_ST]) begin
      ptap[DIV_ST] <= total <= TOT_W'(W_THRESH);
    end
    for (int s = DIV_ST + 1; s < DEPTH; s++) begin
      if (en[s]) begin
        ptap[s] <= ptap[s-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_COMP; j++) begin
      if (!qneg[j] && quo[j][31]) begin
        blend[j] = 32'h7FFF_FFFF;
      end else begin
        blend[j] = qneg[j] ? (~quo[j] + 32'd1) : quo[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DEPTH]) begin
      if (ptap[DEPTH-1]) begin
        out_data.out_pos_x <= vtap[DEPTH-1][0];
        out_data.out_pos_y <= vtap[DEPTH-1][1];
        out_data.out_pos_z <= vtap[DEPTH-1][2];
        out_data.out_nrm_x <= vtap[DEPTH-1][3];
        out_data.out_nrm_y <= vtap[DEPTH-1][4];
        out_data.out_nrm_z <= vtap[DEPTH-1][5];
      end else begin
        out_data.out_pos_x <= blend[0];
        out_data.out_pos_y <= blend[1];
        out_data.out_pos_z <= blend[2];
        out_data.out_nrm_x <= blend[3];
        out_data.out_nrm_y <= blend[4];
        out_data.out_nrm_z <= blend[5];
      end
      out_data.passed_through <= ptap[DEPTH-1];
    end
  end

  `LBS_ASSERT(a_ready_when_drained, !v[DEPTH] |-> in_ready, "input blocked with empty output")
  `LBS_ASSERT(a_ready_on_take, out_ready |-> in_ready, "input blocked while output is taken")
  `LBS_ASSERT_NEXT(a_vertex_enters, vertex_in, v[1], "accepted vertex lost at first stage")

endmodule
